[hw/rtl/vdf_pkg.sv]
// Shared types, constants and saturation helpers for the vector distance unit.
// No dependencies.
package vdf_pkg;

  localparam int ElemWidthDefault = 16;
  localparam int AccW   = 48;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    MetricCos  = 2'd0,
    MetricL1   = 2'd1,
    MetricL2   = 2'd2,
    MetricLinf = 2'd3
  } metric_e;

  typedef struct packed {
    logic signed [AccW-1:0] dacc;
    logic [AccW-1:0]        norm_a;
    logic [AccW-1:0]        norm_b;
    metric_e                metric;
  } job_t;

  function automatic logic signed [AccW-1:0] sat_s(input logic signed [AccW+1:0] v);
    logic signed [AccW+1:0] smax;
    logic signed [AccW+1:0] smin;
    smax = 50'sh0_7FFF_FFFF_FFFF;
    smin = -smax - 50'sd1;
    if (v > smax) begin
      return smax[AccW-1:0];
    end else if (v < smin) begin
      return smin[AccW-1:0];
    end
    return v[AccW-1:0];
  endfunction

  function automatic logic [AccW-1:0] sat_u(input logic [AccW:0] v);
    return v[AccW] ? {AccW{1'b1}} : v[AccW-1:0];
  endfunction

endpackage

[hw/rtl/vdf_front.sv]
// Front end: accepts element pairs and updates the distance and norm accumulators.
// Pushes a finished job on the last pair. Depends on vdf_pkg.
module vdf_front #(
  parameter int ElemWidth = vdf_pkg::ElemWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [ElemWidth-1:0] elem_a_i,
  input  logic signed [ElemWidth-1:0] elem_b_i,
  input  logic                    last_i,
  input  vdf_pkg::metric_e        metric_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output vdf_pkg::job_t           job_o
);

  localparam int W  = ElemWidth;
  localparam int AW = vdf_pkg::AccW;

  logic signed [AW-1:0] acc_d_q, acc_d_d;
  logic [AW-1:0]        na_q, na_d, nb_q, nb_d;
  logic                 acc_en;

  logic signed [W:0]    diff;
  logic [W:0]           dm;
  logic [W-1:0]         am, bm;
  logic signed [2*W-1:0] prod_ab;
  logic [2*W-1:0]       sq_a, sq_b;
  logic [2*W+1:0]       dsq;
  logic [AW:0]          dsq_ext;
  logic signed [AW+1:0] acc_ext, cos_sum, l1_sum, l2_sum;
  logic [AW:0]          na_sq, nb_sq, na_l1, nb_l1;

  assign in_ready_o = !q_full_i;
  assign acc_en     = in_valid_i && in_ready_o;

  always_comb begin
    diff    = {elem_a_i[W-1], elem_a_i} - {elem_b_i[W-1], elem_b_i};
    dm      = diff[W] ? (W+1)'(-diff) : diff;
    am      = elem_a_i[W-1] ? W'(-elem_a_i) : elem_a_i;
    bm      = elem_b_i[W-1] ? W'(-elem_b_i) : elem_b_i;
    prod_ab = elem_a_i * elem_b_i;
    sq_a    = am * am;
    sq_b    = bm * bm;
    dsq     = dm * dm;
    dsq_ext = (AW+1)'(dsq);
    acc_ext = (AW+2)'(acc_d_q);
    cos_sum = acc_ext + (AW+2)'(prod_ab);
    l1_sum  = acc_ext + $signed((AW+2)'(dm));
    l2_sum  = acc_ext + $signed((AW+2)'(vdf_pkg::sat_u(dsq_ext)));
    na_sq   = {1'b0, na_q} + (AW+1)'(sq_a);
    nb_sq   = {1'b0, nb_q} + (AW+1)'(sq_b);
    na_l1   = {1'b0, na_q} + (AW+1)'(am);
    nb_l1   = {1'b0, nb_q} + (AW+1)'(bm);

    unique case (metric_i)
      vdf_pkg::MetricCos: begin
        acc_d_d = vdf_pkg::sat_s(cos_sum);
        na_d    = vdf_pkg::sat_u(na_sq);
        nb_d    = vdf_pkg::sat_u(nb_sq);
      end
      vdf_pkg::MetricL1: begin
        acc_d_d = vdf_pkg::sat_s(l1_sum);
        na_d    = vdf_pkg::sat_u(na_l1);
        nb_d    = vdf_pkg::sat_u(nb_l1);
      end
      vdf_pkg::MetricL2: begin
        acc_d_d = vdf_pkg::sat_s(l2_sum);
        na_d    = vdf_pkg::sat_u(na_sq);
        nb_d    = vdf_pkg::sat_u(nb_sq);
      end
      default: begin
        acc_d_d = (acc_d_q < $signed(AW'(dm))) ? $signed(AW'(dm)) : acc_d_q;
        na_d    = (na_q < AW'(am)) ? AW'(am) : na_q;
        nb_d    = (nb_q < AW'(bm)) ? AW'(bm) : nb_q;
      end
    endcase
  end

  assign push_o        = acc_en && last_i;
  assign job_o.dacc    = acc_d_d;
  assign job_o.norm_a  = na_d;
  assign job_o.norm_b  = nb_d;
  assign job_o.metric  = metric_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_d_q <= '0;
      na_q    <= '0;
      nb_q    <= '0;
    end else if (acc_en) begin
      if (last_i) begin
        acc_d_q <= '0;
        na_q    <= '0;
        nb_q    <= '0;
      end else begin
        acc_d_q <= acc_d_d;
        na_q    <= na_d;
        nb_q    <= nb_d;
      end
    end
  end

endmodule

[hw/rtl/vdf_queue.sv]
// Short job queue between the accumulating front end and the finishing back end.
// Depends on vdf_pkg.
module vdf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vdf_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output vdf_pkg::job_t job_o
);

  localparam int Depth = vdf_pkg::QDepth;
  localparam int PtrW  = $clog2(Depth);

  vdf_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/vdf_back.sv]
// Back end: norm product, long division and (cosine, L2 only) integer square root per
// finished job, then saturation into the output register. Depends on vdf_pkg.
module vdf_back #(
  parameter int ElemWidth = vdf_pkg::ElemWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  vdf_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   distance_o,
  output logic          zero_norm_o
);

  localparam int AW  = vdf_pkg::AccW;
  localparam int HW  = AW / 2;
  localparam int PW  = 2 * AW;
  localparam int NW  = 128;
  localparam int Sh1 = ElemWidth + 15;
  localparam int Sh2 = 2 * ElemWidth + 30;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StSqrt = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0] st_q, st_d;

  logic [AW-1:0]    dmag_q, na_q, nb_q;
  logic             neg_q;
  vdf_pkg::metric_e metric_q;
  logic [1:0]       k_q;
  logic [PW-1:0]    p_q;
  logic [6:0]       cnt_q;
  logic [NW-1:0]    qn_q;
  logic [PW-1:0]    rem_q, den_q;
  logic [NW-1:0]    sn_q, sr_q, sb_q;
  logic [31:0]      res_q;
  logic             zn_q;
  logic             out_valid_q;
  logic [31:0]      dist_q;
  logic             zero_q;

  logic [HW-1:0]    ap, bp;
  logic [AW-1:0]    pp;
  logic [PW-1:0]    pp_sh;
  logic [PW:0]      rem_sh;
  logic             div_ge;
  logic [NW-1:0]    sq_t;
  logic             sq_ge;
  logic [31:0]      fin_res;
  logic             load_out;

  assign ap = k_q[1] ? na_q[AW-1:HW] : na_q[HW-1:0];
  assign bp = k_q[0] ? nb_q[AW-1:HW] : nb_q[HW-1:0];
  assign pp = ap * bp;

  always_comb begin
    unique case (k_q)
      2'd0:    pp_sh = PW'(pp);
      2'd3:    pp_sh = PW'(pp) << AW;
      default: pp_sh = PW'(pp) << HW;
    endcase
  end

  assign rem_sh = {rem_q, qn_q[NW-1]};
  assign div_ge = (rem_sh >= {1'b0, den_q});
  assign sq_t   = sr_q + sb_q;
  assign sq_ge  = (sn_q >= sq_t);

  always_comb begin
    unique case (metric_q)
      vdf_pkg::MetricCos: begin
        if (neg_q) begin
          fin_res = (qn_q > NW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-qn_q[31:0]);
        end else begin
          fin_res = (qn_q > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qn_q[31:0];
        end
      end
      vdf_pkg::MetricL2: begin
        fin_res = (sr_q > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : sr_q[31:0];
      end
      default: begin
        fin_res = (qn_q > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qn_q[31:0];
      end
    endcase
  end

  assign pop_o    = (st_q == StIdle) && job_valid_i;
  assign load_out = (st_q == StDone) && (!out_valid_q || out_ready_i);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (job_valid_i) st_d = StMul;
      StMul:  if (k_q == 2'd3) st_d = StChk;
      StChk: begin
        if (p_q == '0) begin
          st_d = StDone;
        end else if (metric_q == vdf_pkg::MetricCos) begin
          st_d = StSqrt;
        end else begin
          st_d = StDiv;
        end
      end
      StSqrt: begin
        if (sb_q == NW'(1)) begin
          st_d = (metric_q == vdf_pkg::MetricCos) ? StDiv : StFin;
        end
      end
      StDiv: begin
        if (cnt_q == 7'd127) begin
          st_d = (metric_q == vdf_pkg::MetricL2) ? StSqrt : StFin;
        end
      end
      StFin:  st_d = StDone;
      StDone: if (load_out) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      dist_q <= res_q;
      zero_q <= zn_q;
    end
    unique case (st_q)
      StIdle: begin
        dmag_q   <= job_i.dacc[AW-1] ? AW'(-job_i.dacc) : AW'(job_i.dacc);
        neg_q    <= job_i.dacc[AW-1];
        na_q     <= job_i.norm_a;
        nb_q     <= job_i.norm_b;
        metric_q <= job_i.metric;
        k_q      <= '0;
        p_q      <= '0;
      end
      StMul: begin
        p_q <= p_q + pp_sh;
        k_q <= k_q + 1'b1;
      end
      StChk: begin
        zn_q  <= (p_q == '0);
        res_q <= '0;
        cnt_q <= '0;
        rem_q <= '0;
        den_q <= p_q;
        sn_q  <= NW'(p_q);
        sr_q  <= '0;
        sb_q  <= NW'(1) << (NW - 2);
        if (metric_q == vdf_pkg::MetricL2) begin
          qn_q <= NW'(dmag_q) << Sh2;
        end else begin
          qn_q <= NW'(dmag_q) << Sh1;
        end
      end
      StSqrt: begin
        if (sq_ge) begin
          sn_q <= sn_q - sq_t;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
        if (sb_q == NW'(1) && metric_q == vdf_pkg::MetricCos) begin
          den_q <= PW'(sq_ge ? (sr_q >> 1) + sb_q : sr_q >> 1);
          qn_q  <= NW'(dmag_q) << 16;
          rem_q <= '0;
          cnt_q <= '0;
        end
      end
      StDiv: begin
        rem_q <= div_ge ? PW'(rem_sh - {1'b0, den_q}) : PW'(rem_sh);
        qn_q  <= {qn_q[NW-2:0], div_ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 7'd127) begin
          sn_q <= {qn_q[NW-2:0], div_ge};
          sr_q <= '0;
          sb_q <= NW'(1) << (NW - 2);
        end
      end
      StFin: begin
        res_q <= fin_res;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign zero_norm_o = zero_q;

endmodule

[hw/rtl/vector_distance_four_metrics_unit.sv]
// Streaming cosine / L1 / L2 / Linf normalized distance over element pairs.
// The back end runs a bit-serial 128-step divider for every metric and a 64-step square root
// for L2 and cosine; a zero norm product skips both.
// Throughput: one pair per cycle while the two-entry job queue has room.
// Reset: asynchronous, active low; clears accumulators, queue, metric and output valid.
module vector_distance_four_metrics_unit #(
  parameter int ELEM_WIDTH = vdf_pkg::ElemWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [ELEM_WIDTH-1:0] elem_a_i,
  input  logic signed [ELEM_WIDTH-1:0] elem_b_i,
  input  logic                        last_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          distance_o,
  output logic                        zero_norm_o
);

  vdf_pkg::metric_e metric_q;
  logic             q_full, push, job_valid, pop;
  vdf_pkg::job_t    job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= vdf_pkg::MetricCos;
    end else if (cfg_we_i) begin
      metric_q <= vdf_pkg::metric_e'(cfg_data_i);
    end
  end

  vdf_front #(.ElemWidth(ELEM_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .elem_a_i   (elem_a_i),
    .elem_b_i   (elem_b_i),
    .last_i     (last_i),
    .metric_i   (metric_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in)
  );

  vdf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  vdf_back #(.ElemWidth(ELEM_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .distance_o  (distance_o),
    .zero_norm_o (zero_norm_o)
  );

endmodule

[hw/rtl/vdf_checker.sv]
// Port-level checks for the vector distance unit, bound to the top level.
// Depends on vector_distance_four_metrics_unit.
module vdf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] distance_o,
  input logic        zero_norm_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o) && $stable(zero_norm_o))
    else $error("result beat changed while stalled");

  a_zero_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_norm_o |-> distance_o == 32'd0)
    else $error("zero norm with nonzero distance");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind vector_distance_four_metrics_unit vdf_checker u_vdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .distance_o  (distance_o),
  .zero_norm_o (zero_norm_o)
);
